// ===== src/bresenham_line_stepper_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the line stepper
// Shared property wrappers needing clock in scope; the masked ones need reset.
// ----------------------------------------------------------------------------
`ifndef BRESENHAM_LINE_STEPPER_DEFINES_SVH
`define BRESENHAM_LINE_STEPPER_DEFINES_SVH

// Same-cycle implication, masked while reset is high
`define BLS_ASSERT_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, masked while reset is high
`define BLS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// Next-cycle implication that also checks across reset
`define BLS_ASSERT_ALWAYS_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/bls_pkg.sv =====
// ----------------------------------------------------------------------------
// bls_pkg
// Opcodes and fixed sizes shared by the line stepper modules.
// ----------------------------------------------------------------------------
package bls_pkg;

   // request kinds carried on req_tuser
   typedef enum logic {
      OP_START = 1'b0,
      OP_STEP  = 1'b1
   } op_type;

   localparam int COLOR_BITS     = 16;
   localparam int QUEUE_DEPTH    = 4;
   localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);

endpackage

// ===== src/bls_front.sv =====
// ----------------------------------------------------------------------------
// bls_front
// Accepts request transactions and works out the line setup for a start.
// ----------------------------------------------------------------------------
module bls_front
   import bls_pkg::*;
#(
   parameter int  COORD_BITS = 9,
   localparam int ERR_BITS   = COORD_BITS + 3,
   localparam int REQ_W      = ((4 * COORD_BITS + COLOR_BITS + 7) / 8) * 8,
   localparam int ENTRY_W    = 3 * COORD_BITS + 3 * ERR_BITS + 5 + COLOR_BITS
) (
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [REQ_W-1:0]   req_tdata,
   input  logic               req_tuser,
   output logic               q_wr_valid,
   input  logic               q_wr_ready,
   output logic [ENTRY_W-1:0] q_wr_data
);

   typedef struct packed {
      op_type                     op;
      logic [COORD_BITS-1:0]      major_pos;
      logic [COORD_BITS-1:0]      minor_pos;
      logic [COORD_BITS-1:0]      major_end;
      logic signed [ERR_BITS-1:0] error;
      logic signed [ERR_BITS-1:0] inc_straight;
      logic signed [ERR_BITS-1:0] inc_diagonal;
      logic                       major_neg;
      logic                       minor_neg;
      logic                       swapped;
      logic                       single;
      logic [COLOR_BITS-1:0]      color;
   } entry_type;

   logic [COORD_BITS-1:0] xs, ys, xe, ye;
   logic [COORD_BITS-1:0] dx, dy, d_major, d_minor;
   logic [COORD_BITS-1:0] minor_end;
   logic                  swap;
   entry_type             entry;

   // unpack the endpoints
   assign xs = req_tdata[COORD_BITS-1:0];
   assign ys = req_tdata[2*COORD_BITS-1:COORD_BITS];
   assign xe = req_tdata[3*COORD_BITS-1:2*COORD_BITS];
   assign ye = req_tdata[4*COORD_BITS-1:3*COORD_BITS];

   // absolute extents and major axis choice
   assign dx      = (xe >= xs) ? (xe - xs) : (xs - xe);
   assign dy      = (ye >= ys) ? (ye - ys) : (ys - ye);
   assign swap    = (dx < dy);
   assign d_major = swap ? dy : dx;
   assign d_minor = swap ? dx : dy;

   // build the queue entry
   always_comb begin
      entry              = '0;
      entry.op           = op_type'(req_tuser);
      entry.swapped      = swap;
      entry.major_pos    = swap ? ys : xs;
      entry.minor_pos    = swap ? xs : ys;
      entry.major_end    = swap ? ye : xe;
      minor_end          = swap ? xe : ye;
      entry.major_neg    = !(entry.major_end > entry.major_pos);
      entry.minor_neg    = !(minor_end > entry.minor_pos);
      entry.inc_straight = signed'({2'b00, d_minor, 1'b0});
      entry.inc_diagonal = signed'({2'b00, d_minor, 1'b0}) - signed'({2'b00, d_major, 1'b0});
      entry.error        = signed'({2'b00, d_minor, 1'b0}) - signed'({3'b000, d_major});
      entry.single       = (xs == xe) && (ys == ye);
      entry.color        = req_tdata[4*COORD_BITS+COLOR_BITS-1:4*COORD_BITS];
   end

   // pass the handshake through to the queue
   assign req_tready = q_wr_ready;
   assign q_wr_valid = req_tvalid;
   assign q_wr_data  = entry;

endmodule

// ===== src/bls_queue.sv =====
// ----------------------------------------------------------------------------
// bls_queue
// Small FIFO that decouples request setup from pixel stepping.
// ----------------------------------------------------------------------------
module bls_queue
   import bls_pkg::*;
#(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             wr_valid,
   output logic             wr_ready,
   input  logic [WIDTH-1:0] wr_data,
   output logic             rd_valid,
   input  logic             rd_pop,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0]          mem_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_BITS-1:0] count_ff, count_in;
   logic                      push, pop;

   assign wr_ready = (count_ff != QUEUE_CNT_BITS'(QUEUE_DEPTH));
   assign rd_valid = (count_ff != '0);
   assign push     = wr_valid && wr_ready;
   assign pop      = rd_pop && rd_valid;
   assign rd_data  = mem_ff[rd_ptr_ff];

   // advance pointers and occupancy
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QUEUE_PTR_BITS'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + QUEUE_PTR_BITS'(1) : rd_ptr_ff;
      count_in  = count_ff + QUEUE_CNT_BITS'(push) - QUEUE_CNT_BITS'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // store the entry
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

// ===== src/bls_back.sv =====
// ----------------------------------------------------------------------------
// bls_back
// Holds the line state, steps the error term and registers each pixel.
// ----------------------------------------------------------------------------
module bls_back
   import bls_pkg::*;
#(
   parameter int  COORD_BITS = 9,
   localparam int ERR_BITS   = COORD_BITS + 3,
   localparam int RSP_W      = ((2 * COORD_BITS + COLOR_BITS + 7) / 8) * 8,
   localparam int ENTRY_W    = 3 * COORD_BITS + 3 * ERR_BITS + 5 + COLOR_BITS
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               q_valid,
   output logic               q_pop,
   input  logic [ENTRY_W-1:0] q_data,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [RSP_W-1:0]   rsp_tdata,
   output logic               rsp_tlast
);

   typedef struct packed {
      op_type                     op;
      logic [COORD_BITS-1:0]      major_pos;
      logic [COORD_BITS-1:0]      minor_pos;
      logic [COORD_BITS-1:0]      major_end;
      logic signed [ERR_BITS-1:0] error;
      logic signed [ERR_BITS-1:0] inc_straight;
      logic signed [ERR_BITS-1:0] inc_diagonal;
      logic                       major_neg;
      logic                       minor_neg;
      logic                       swapped;
      logic                       single;
      logic [COLOR_BITS-1:0]      color;
   } entry_type;

   entry_type ent;

   // line state
   logic [COORD_BITS-1:0]      major_pos_ff, major_pos_in;
   logic [COORD_BITS-1:0]      minor_pos_ff, minor_pos_in;
   logic [COORD_BITS-1:0]      major_end_ff, major_end_in;
   logic signed [ERR_BITS-1:0] error_ff, error_in;
   logic signed [ERR_BITS-1:0] inc_str_ff, inc_str_in;
   logic signed [ERR_BITS-1:0] inc_diag_ff, inc_diag_in;
   logic                       major_neg_ff, major_neg_in;
   logic                       minor_neg_ff, minor_neg_in;
   logic                       swapped_ff, swapped_in;
   logic                       active_ff, active_in;
   logic [COLOR_BITS-1:0]      color_ff, color_in;

   // output register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [COORD_BITS-1:0] px_ff, px_in;
   logic [COORD_BITS-1:0] py_ff, py_in;
   logic [COLOR_BITS-1:0] pcolor_ff, pcolor_in;
   logic                  plast_ff, plast_in;

   // step results
   logic [COORD_BITS-1:0]      major_nxt, minor_nxt, minor_stp;
   logic signed [ERR_BITS-1:0] error_nxt;
   logic                       err_neg, at_end, out_free;

   assign ent      = entry_type'(q_data);
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign q_pop    = q_valid && out_free;

   // one Bresenham move along the major axis
   assign err_neg   = error_ff[ERR_BITS-1];
   assign major_nxt = major_neg_ff ? major_pos_ff - COORD_BITS'(1)
                                   : major_pos_ff + COORD_BITS'(1);
   assign minor_stp = minor_neg_ff ? minor_pos_ff - COORD_BITS'(1)
                                   : minor_pos_ff + COORD_BITS'(1);
   assign minor_nxt = err_neg ? minor_pos_ff : minor_stp;
   assign error_nxt = error_ff + (err_neg ? inc_str_ff : inc_diag_ff);
   assign at_end    = (major_nxt == major_end_ff);

   // next state and next pixel
   always_comb begin
      major_pos_in = major_pos_ff;
      minor_pos_in = minor_pos_ff;
      major_end_in = major_end_ff;
      error_in     = error_ff;
      inc_str_in   = inc_str_ff;
      inc_diag_in  = inc_diag_ff;
      major_neg_in = major_neg_ff;
      minor_neg_in = minor_neg_ff;
      swapped_in   = swapped_ff;
      active_in    = active_ff;
      color_in     = color_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      px_in        = px_ff;
      py_in        = py_ff;
      pcolor_in    = pcolor_ff;
      plast_in     = plast_ff;
      if (q_pop) begin
         case (ent.op)
            OP_START: begin
               major_pos_in = ent.major_pos;
               minor_pos_in = ent.minor_pos;
               major_end_in = ent.major_end;
               error_in     = ent.error;
               inc_str_in   = ent.inc_straight;
               inc_diag_in  = ent.inc_diagonal;
               major_neg_in = ent.major_neg;
               minor_neg_in = ent.minor_neg;
               swapped_in   = ent.swapped;
               color_in     = ent.color;
               active_in    = !ent.single;
               rsp_valid_in = 1'b1;
               px_in        = ent.swapped ? ent.minor_pos : ent.major_pos;
               py_in        = ent.swapped ? ent.major_pos : ent.minor_pos;
               pcolor_in    = ent.color;
               plast_in     = ent.single;
            end
            OP_STEP: begin
               // drop steps while no line is running
               if (active_ff) begin
                  major_pos_in = major_nxt;
                  minor_pos_in = minor_nxt;
                  error_in     = error_nxt;
                  active_in    = !at_end;
                  rsp_valid_in = 1'b1;
                  px_in        = swapped_ff ? minor_nxt : major_nxt;
                  py_in        = swapped_ff ? major_nxt : minor_nxt;
                  pcolor_in    = color_ff;
                  plast_in     = at_end;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload and line parameters
   always_ff @(posedge clock) begin
      major_pos_ff <= major_pos_in;
      minor_pos_ff <= minor_pos_in;
      major_end_ff <= major_end_in;
      error_ff     <= error_in;
      inc_str_ff   <= inc_str_in;
      inc_diag_ff  <= inc_diag_in;
      major_neg_ff <= major_neg_in;
      minor_neg_ff <= minor_neg_in;
      swapped_ff   <= swapped_in;
      color_ff     <= color_in;
      px_ff        <= px_in;
      py_ff        <= py_in;
      pcolor_ff    <= pcolor_in;
      plast_ff     <= plast_in;
   end

   // pack the result transaction
   always_comb begin
      rsp_tdata                                          = '0;
      rsp_tdata[COORD_BITS-1:0]                          = px_ff;
      rsp_tdata[2*COORD_BITS-1:COORD_BITS]               = py_ff;
      rsp_tdata[2*COORD_BITS+COLOR_BITS-1:2*COORD_BITS]  = pcolor_ff;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = plast_ff;

endmodule

// ===== src/bresenham_line_stepper.sv =====
// Bresenham line stepper.
// Request channel (req_): tuser is the opcode, start or step. A start carries
// both endpoints and a color in tdata and yields the first pixel at once; each
// step yields the next pixel along the line. A step with no line running
// yields nothing; a start while a line runs drops that line.
// Result channel (rsp_): one pixel per transaction, tlast marks the end point.
// A line with equal endpoints gives a single pixel with tlast set.
// Path: a request is set up and written into the queue at the accepting edge,
// and is stepped into the output register when the stepper pops it from the
// queue; a held output register or older queued entries can delay that.
// Throughput: one request and one pixel per cycle while rsp_tready is high.
// A four-entry queue sits between setup and stepping; when the receiver holds
// rsp_tready low the output register holds, the queue fills, and req_tready
// drops once it is full.
// Reset clears the queue, the output register and the running-line flag.
// ----------------------------------------------------------------------------
// bresenham_line_stepper
// Top level: request setup, decoupling queue and pixel stepper.
// ----------------------------------------------------------------------------
module bresenham_line_stepper
   import bls_pkg::*;
#(
   parameter int  COORD_BITS = 9,
   localparam int ERR_BITS   = COORD_BITS + 3,
   localparam int REQ_W      = ((4 * COORD_BITS + COLOR_BITS + 7) / 8) * 8,
   localparam int RSP_W      = ((2 * COORD_BITS + COLOR_BITS + 7) / 8) * 8,
   localparam int ENTRY_W    = 3 * COORD_BITS + 3 * ERR_BITS + 5 + COLOR_BITS
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   // x_start, y_start, x_end, y_end, pen_color, zero fill
   input  logic [REQ_W-1:0] req_tdata,
   // opcode
   input  logic             req_tuser,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   // pixel_x, pixel_y, pixel_color, zero fill
   output logic [RSP_W-1:0] rsp_tdata,
   // last_pixel
   output logic             rsp_tlast
);

   logic               q_wr_valid, q_wr_ready, q_rd_valid, q_rd_pop;
   logic [ENTRY_W-1:0] q_wr_data, q_rd_data;

   // classify and set up requests
   bls_front #(.COORD_BITS(COORD_BITS)) u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_wr_valid (q_wr_valid),
      .q_wr_ready (q_wr_ready),
      .q_wr_data  (q_wr_data)
   );

   // decouple front and back
   bls_queue #(.WIDTH(ENTRY_W)) u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (q_wr_valid),
      .wr_ready (q_wr_ready),
      .wr_data  (q_wr_data),
      .rd_valid (q_rd_valid),
      .rd_pop   (q_rd_pop),
      .rd_data  (q_rd_data)
   );

   // step lines and emit pixels
   bls_back #(.COORD_BITS(COORD_BITS)) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_rd_valid),
      .q_pop      (q_rd_pop),
      .q_data     (q_rd_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// ===== src/bls_checker.sv =====
// ----------------------------------------------------------------------------
// bls_checker
// Port-level checks on the line stepper, bound to the top level.
// ----------------------------------------------------------------------------
`include "bresenham_line_stepper_defines.svh"

module bls_checker
   import bls_pkg::*;
#(
   parameter int  COORD_BITS = 9,
   localparam int RSP_W      = ((2 * COORD_BITS + COLOR_BITS + 7) / 8) * 8
) (
   input logic             clock,
   input logic             reset,
   input logic             req_tready,
   input logic             rsp_tvalid,
   input logic             rsp_tready,
   input logic [RSP_W-1:0] rsp_tdata,
   input logic             rsp_tlast
);

   // a stalled result transaction holds its payload
   `BLS_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready,
      rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast),
      "result changed while stalled")

   // reset empties the output register
   `BLS_ASSERT_ALWAYS_NEXT(a_reset_idle, reset, !rsp_tvalid,
      "result valid right after reset")

   // the request side only backs up behind a stalled result
   `BLS_ASSERT_IMPLY(a_ready_backpressure, !req_tready,
      $past(rsp_tvalid && !rsp_tready), "request ready dropped without a stall")

   // a stalled result is not withdrawn while rsp_tlast and rsp_tready are high
   `BLS_ASSERT_IMPLY(a_tlast_valid, rsp_tlast && rsp_tready && !rsp_tvalid,
      !$past(rsp_tvalid && !rsp_tready), "stalled result was lost")

endmodule

bind bresenham_line_stepper bls_checker #(.COORD_BITS(COORD_BITS)) u_bls_checker (.*);
